[design/mbr_pkg.sv]
// Shared types, codes and helper functions for the Modbus RTU master engine.
`timescale 1ns / 1ps
`default_nettype none
package mbr_pkg;

    localparam int TABLE_DEPTH_DEF = 8;
    localparam int MAX_RESULTS = 9;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RX_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    localparam logic [1:0] KIND_TX_BYTE = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_TIMEOUT = 2'd3;

    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [1:0] CFG_SILENCE = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_RETIRE = 2'd2;

    localparam logic [7:0] SILENCE_RST = 8'd5;
    localparam logic [15:0] TIMEOUT_RST = 16'd2000;
    localparam logic [15:0] RETIRE_RST = 16'd5000;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [8:0] MIN_FRAME = 9'd5;
    localparam logic [8:0] LEN_MAX = 9'd256;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  slave_addr;
        logic [7:0]  func_code;
        logic [15:0] reg_addr;
        logic [15:0] count_or_value;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] txn_id;
        logic [7:0]  tx_byte;
        logic [8:0]  frame_length;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    valid;
        logic    full;
        logic    push;
        result_t data;
    } oq_ctl_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic [7:0] frame_byte(input item_t it, input logic [15:0] crc,
                                              input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0: b = it.slave_addr;
            3'd1: b = it.func_code;
            3'd2: b = it.reg_addr[15:8];
            3'd3: b = it.reg_addr[7:0];
            3'd4: b = it.count_or_value[15:8];
            3'd5: b = it.count_or_value[7:0];
            3'd6: b = crc[7:0];
            default: b = crc[15:8];
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

[design/mbr_front.sv]
// Front end: takes input requests into a two-entry queue ahead of the engine.
`timescale 1ns / 1ps
`default_nettype none
module mbr_front
    import mbr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire item_t       in_item,
    output logic             item_valid,
    output item_t            item,
    input  wire logic        item_pop
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;
    item_t      clean_item;

    // Operation code 3 has no effect, so it is dropped here instead of in the engine.
    always_comb
    begin
        clean_item = in_item;
        do_push = push && !full && (in_item.operation != OP_IGNORED);
        do_pop = item_pop && item_valid;
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(do_push) - 2'(do_pop);
    end

    assign full = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= clean_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

[design/mbr_outq.sv]
// Result queue between the engine and the result ports.
`timescale 1ns / 1ps
`default_nettype none
module mbr_outq
    import mbr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire result_t wr_data,
    output logic         full,
    output logic         empty,
    input  wire logic    pop,
    output result_t      rd_data
);

    result_t    mem_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        do_push = wr_en && !full;
        do_pop = pop && !empty;
        wr_ptr_next = wr_ptr_reg + 2'(do_push);
        rd_ptr_next = rd_ptr_reg + 2'(do_pop);
        count_next = count_reg + 3'(do_push) - 3'(do_pop);
    end

    assign full = (count_reg == 3'd4);
    assign empty = (count_reg == 3'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

[design/mbr_engine.sv]
// Back end: transaction table, frame builder, receive framing and the timer sweep.
`timescale 1ns / 1ps
`default_nettype none
module mbr_engine
    import mbr_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        item_valid,
    input  wire item_t       item,
    output logic             item_pop,
    input  wire logic        oq_full,
    output oq_ctl_t          oq
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_REQ_CRC    = 8'b0000_0010,
        S_REQ_EMIT   = 8'b0000_0100,
        S_CLOSE_SCAN = 8'b0000_1000,
        S_CLOSE_DONE = 8'b0001_0000,
        S_BYTE       = 8'b0010_0000,
        S_SWEEP      = 8'b0100_0000,
        S_FINISH     = 8'b1000_0000
    } state_t;

    // Transaction table
    logic        entry_valid_reg  [TABLE_DEPTH];
    logic [31:0] entry_id_reg     [TABLE_DEPTH];
    logic [7:0]  entry_slave_reg  [TABLE_DEPTH];
    logic [7:0]  entry_func_reg   [TABLE_DEPTH];
    logic [1:0]  entry_status_reg [TABLE_DEPTH];
    logic [31:0] entry_stamp_reg  [TABLE_DEPTH];

    state_t      state_reg, state_next;
    item_t       item_reg, item_next;
    logic [7:0]  silence_reg;
    logic [15:0] timeout_reg;
    logic [15:0] retire_reg;
    logic [31:0] next_id_reg, next_id_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] last_byte_reg, last_byte_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic [8:0]  rx_len_reg, rx_len_next;
    logic [7:0]  rx_addr_reg, rx_addr_next;
    logic [7:0]  rx_func_reg, rx_func_next;
    logic [15:0] tx_crc_reg, tx_crc_next;
    logic [31:0] txid_reg, txid_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic        best_valid_reg, best_valid_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [31:0] best_age_reg, best_age_next;
    logic [3:0]  res_cnt_reg, res_cnt_next;
    logic        hold_valid_reg, hold_valid_next;
    result_t     hold_reg, hold_next;

    logic        free_found;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] rd_idx;
    logic        emit_req;
    result_t     emit_data;
    logic        emit_ok;
    logic        new_wr;
    logic        status_wr;
    logic [1:0]  status_val;
    logic [IDX_W-1:0] status_idx;
    logic        retire_wr;
    logic [31:0] now_eff;
    logic        silence_passed;
    logic        match;
    logic [31:0] age;
    logic        to_hit;
    logic [1:0]  eff_status;
    state_t      after_close;

    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!entry_valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // One table read port: the winner during completion, the sweep index otherwise.
    assign rd_idx = (state_reg == S_CLOSE_DONE) ? best_idx_reg : idx_reg;
    assign emit_ok = !hold_valid_reg || !oq_full;

    always_comb
    begin
        now_eff = (item.operation == OP_TICK) ? (now_reg + 32'd1) : now_reg;
        silence_passed = (rx_len_reg != 9'd0) &&
                         ((now_eff - last_byte_reg) > {24'd0, silence_reg});
        match = entry_valid_reg[rd_idx] && (entry_status_reg[rd_idx] == ST_PENDING) &&
                (entry_slave_reg[rd_idx] == rx_addr_reg) &&
                (entry_func_reg[rd_idx] == rx_func_reg);
        age = (state_reg == S_SWEEP) ? (now_reg - entry_stamp_reg[rd_idx])
                                     : (next_id_reg - entry_id_reg[rd_idx]);
        to_hit = entry_valid_reg[rd_idx] && (entry_status_reg[rd_idx] == ST_PENDING) &&
                 (age > {16'd0, timeout_reg}) && (res_cnt_reg < 4'(MAX_RESULTS));
        eff_status = to_hit ? ST_TIMEOUT : entry_status_reg[rd_idx];
        after_close = (item_reg.operation == OP_RX_BYTE) ? S_BYTE : S_SWEEP;
    end

    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        next_id_next = next_id_reg;
        now_next = now_reg;
        last_byte_next = last_byte_reg;
        rx_crc_next = rx_crc_reg;
        rx_len_next = rx_len_reg;
        rx_addr_next = rx_addr_reg;
        rx_func_next = rx_func_reg;
        tx_crc_next = tx_crc_reg;
        txid_next = txid_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        best_valid_next = best_valid_reg;
        best_idx_next = best_idx_reg;
        best_age_next = best_age_reg;
        res_cnt_next = res_cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_next = hold_reg;
        item_pop = 1'b0;
        emit_req = 1'b0;
        emit_data = '0;
        new_wr = 1'b0;
        status_wr = 1'b0;
        status_val = ST_PENDING;
        status_idx = rd_idx;
        retire_wr = 1'b0;
        oq.valid = hold_valid_reg;
        oq.full = oq_full;
        oq.push = 1'b0;
        oq.data = hold_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    item_next = item;
                    res_cnt_next = 4'd0;
                    idx_next = '0;
                    if (item.operation == OP_REQUEST)
                    begin
                        if (!free_found)
                        begin
                            emit_req = 1'b1;
                            emit_data.kind = KIND_REJECT;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            new_wr = 1'b1;
                            txid_next = next_id_reg;
                            next_id_next = (next_id_reg == 32'hFFFF_FFFF) ? 32'd1
                                                                         : next_id_reg + 32'd1;
                            tx_crc_next = CRC_INIT;
                            cnt_next = 3'd0;
                            state_next = S_REQ_CRC;
                        end
                    end
                    else
                    begin
                        now_next = now_eff;
                        if (silence_passed && (rx_len_reg >= MIN_FRAME) &&
                            (rx_crc_reg == 16'd0))
                        begin
                            best_valid_next = 1'b0;
                            state_next = S_CLOSE_SCAN;
                        end
                        else
                        begin
                            if (silence_passed)
                            begin
                                rx_crc_next = CRC_INIT;
                                rx_len_next = 9'd0;
                            end
                            state_next = (item.operation == OP_RX_BYTE) ? S_BYTE : S_SWEEP;
                        end
                    end
                end
            end
            S_REQ_CRC:
            begin
                tx_crc_next = crc_feed(tx_crc_reg, frame_byte(item_reg, tx_crc_reg, cnt_reg));
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    cnt_next = 3'd0;
                    state_next = S_REQ_EMIT;
                end
            end
            S_REQ_EMIT:
            begin
                emit_req = 1'b1;
                emit_data.kind = KIND_TX_BYTE;
                emit_data.txn_id = txid_reg;
                emit_data.tx_byte = frame_byte(item_reg, tx_crc_reg, cnt_reg);
                if (emit_ok)
                begin
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_CLOSE_SCAN:
            begin
                // The earliest issued match has the largest distance behind next_id.
                if (match && (!best_valid_reg || (age > best_age_reg)))
                begin
                    best_valid_next = 1'b1;
                    best_idx_next = idx_reg;
                    best_age_next = age;
                end
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next = '0;
                    state_next = S_CLOSE_DONE;
                end
            end
            S_CLOSE_DONE:
            begin
                if (best_valid_reg)
                begin
                    emit_req = 1'b1;
                    emit_data.kind = KIND_DONE;
                    emit_data.txn_id = entry_id_reg[rd_idx];
                    emit_data.frame_length = rx_len_reg;
                end
                if (!best_valid_reg || emit_ok)
                begin
                    if (best_valid_reg)
                    begin
                        status_wr = 1'b1;
                        status_val = ST_DONE;
                        res_cnt_next = res_cnt_reg + 4'd1;
                    end
                    rx_crc_next = CRC_INIT;
                    rx_len_next = 9'd0;
                    state_next = after_close;
                end
            end
            S_BYTE:
            begin
                if (rx_len_reg == 9'd0)
                begin
                    rx_addr_next = item_reg.rx_byte;
                end
                if (rx_len_reg == 9'd1)
                begin
                    rx_func_next = item_reg.rx_byte;
                end
                rx_crc_next = crc_feed(rx_crc_reg, item_reg.rx_byte);
                if (rx_len_reg < LEN_MAX)
                begin
                    rx_len_next = rx_len_reg + 9'd1;
                end
                last_byte_next = now_reg;
                state_next = S_FINISH;
            end
            S_SWEEP:
            begin
                if (to_hit)
                begin
                    emit_req = 1'b1;
                    emit_data.kind = KIND_TIMEOUT;
                    emit_data.txn_id = entry_id_reg[rd_idx];
                end
                if (!to_hit || emit_ok)
                begin
                    if (to_hit)
                    begin
                        status_wr = 1'b1;
                        status_val = ST_TIMEOUT;
                        res_cnt_next = res_cnt_reg + 4'd1;
                    end
                    retire_wr = entry_valid_reg[rd_idx] && (eff_status != ST_PENDING) &&
                                (age > {16'd0, retire_reg});
                    idx_next = idx_reg + IDX_W'(1);
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next = '0;
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!oq_full)
                begin
                    oq.push = 1'b1;
                    oq.data.last = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A result waits in the hold register until the next one shows it is not the last.
        if (emit_req && emit_ok)
        begin
            oq.push = hold_valid_reg;
            oq.data.last = 1'b0;
            hold_next = emit_data;
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        tx_crc_reg <= tx_crc_next;
        txid_reg <= txid_next;
        best_idx_reg <= best_idx_next;
        best_age_reg <= best_age_next;
        hold_reg <= hold_next;
        if (new_wr)
        begin
            entry_id_reg[free_idx] <= next_id_reg;
            entry_slave_reg[free_idx] <= item.slave_addr;
            entry_func_reg[free_idx] <= item.func_code;
            entry_stamp_reg[free_idx] <= now_reg;
        end
        if (new_wr)
        begin
            entry_status_reg[free_idx] <= ST_PENDING;
        end
        else if (status_wr)
        begin
            entry_status_reg[status_idx] <= status_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
            end
            state_reg <= S_IDLE;
            silence_reg <= SILENCE_RST;
            timeout_reg <= TIMEOUT_RST;
            retire_reg <= RETIRE_RST;
            next_id_reg <= 32'd1;
            now_reg <= 32'd0;
            last_byte_reg <= 32'd0;
            rx_crc_reg <= CRC_INIT;
            rx_len_reg <= 9'd0;
            rx_addr_reg <= 8'd0;
            rx_func_reg <= 8'd0;
            cnt_reg <= 3'd0;
            idx_reg <= '0;
            best_valid_reg <= 1'b0;
            res_cnt_reg <= 4'd0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (new_wr)
            begin
                entry_valid_reg[free_idx] <= 1'b1;
            end
            if (retire_wr)
            begin
                entry_valid_reg[rd_idx] <= 1'b0;
            end
            if (cfg_wr && (cfg_index == CFG_SILENCE))
            begin
                silence_reg <= cfg_data[7:0];
            end
            if (cfg_wr && (cfg_index == CFG_TIMEOUT))
            begin
                timeout_reg <= cfg_data;
            end
            if (cfg_wr && (cfg_index == CFG_RETIRE))
            begin
                retire_reg <= cfg_data;
            end
            state_reg <= state_next;
            next_id_reg <= next_id_next;
            now_reg <= now_next;
            last_byte_reg <= last_byte_next;
            rx_crc_reg <= rx_crc_next;
            rx_len_reg <= rx_len_next;
            rx_addr_reg <= rx_addr_next;
            rx_func_reg <= rx_func_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            best_valid_reg <= best_valid_next;
            res_cnt_reg <= res_cnt_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        oq.push |-> !oq_full)
        else $error("result pushed into a full queue");
    a_hold_empty_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_valid_reg)
        else $error("held result left over between requests");
    a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= 4'(MAX_RESULTS))
        else $error("too many results for one request");
    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != 32'd0)
        else $error("transaction id counter reached zero");
`endif

endmodule
`default_nettype wire

[design/modbus_rtu_master_transaction_engine.sv]
// Top level of the Modbus RTU master transaction engine.
//
//  channel   handshake             payload
//  input     push / full           operation slave_addr func_code reg_addr count_or_value rx_byte
//  result    empty / pop           kind txn_id tx_byte frame_length last
//  config    cfg_valid / cfg_ready cfg_index cfg_data
//
// A request passes accept, a CRC state over the six leading bytes, an emit state for the
// eight frame bytes and a finish state for the last result; a rejection goes from accept to
// finish. A byte passes accept, byte and finish; a tick sweeps the table and a frame close
// adds a table scan and a completion state. The single table read port sets these table passes.
// Reset clears the table valid bits, queues and counters at once; no clearing pass.
// A full result queue stalls the engine; the two-entry input queue takes requests until full.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_master_transaction_engine
    import mbr_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  slave_addr,
    input  wire logic [7:0]  func_code,
    input  wire logic [15:0] reg_addr,
    input  wire logic [15:0] count_or_value,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       kind,
    output logic [31:0]      txn_id,
    output logic [7:0]       tx_byte,
    output logic [8:0]       frame_length,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    item_pop;
    oq_ctl_t oq;
    logic    oq_full;
    result_t res;

    assign in_item = '{operation: operation, slave_addr: slave_addr, func_code: func_code,
                       reg_addr: reg_addr, count_or_value: count_or_value, rx_byte: rx_byte};
    assign cfg_ready = 1'b1;

    mbr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    oq_ctl_t oq_in;

    always_comb
    begin
        oq_in = oq;
        oq_in.full = oq_full;
    end

    mbr_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .oq_full    (oq_full),
        .oq         (oq)
    );

    mbr_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (oq_in.push),
        .wr_data (oq_in.data),
        .full    (oq_full),
        .empty   (empty),
        .pop     (pop),
        .rd_data (res)
    );

    assign kind = res.kind;
    assign txn_id = res.txn_id;
    assign tx_byte = res.tx_byte;
    assign frame_length = res.frame_length;
    assign last = res.last;

endmodule
`default_nettype wire

[tb/sv/tb_modbus_rtu_master_transaction_engine.sv]
// Self-checking testbench for the Modbus RTU master transaction engine.
`timescale 1ns / 1ps
module tb_modbus_rtu_master_transaction_engine;
    import mbr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  operation;
    logic [7:0]  slave_addr;
    logic [7:0]  func_code;
    logic [15:0] reg_addr;
    logic [15:0] count_or_value;
    logic [7:0]  rx_byte;
    logic        empty;
    logic        pop;
    logic [1:0]  kind;
    logic [31:0] txn_id;
    logic [7:0]  tx_byte;
    logic [8:0]  frame_length;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    modbus_rtu_master_transaction_engine u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .operation(operation),
        .slave_addr(slave_addr), .func_code(func_code), .reg_addr(reg_addr),
        .count_or_value(count_or_value), .rx_byte(rx_byte), .empty(empty), .pop(pop),
        .kind(kind), .txn_id(txn_id), .tx_byte(tx_byte), .frame_length(frame_length),
        .last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    localparam int DEPTH = TABLE_DEPTH_DEF;

    // Shadow copy of the engine state.
    logic [7:0]  sil_ms;
    logic [15:0] tmo_ms;
    logic [15:0] ret_ms;
    logic        tb_valid [DEPTH];
    logic [31:0] tb_id [DEPTH];
    logic [7:0]  tb_slave [DEPTH];
    logic [7:0]  tb_func [DEPTH];
    logic [1:0]  tb_status [DEPTH];
    logic [31:0] tb_stamp [DEPTH];
    logic [31:0] id_next;
    logic [31:0] ms_now;
    logic [31:0] ms_last_byte;
    logic [15:0] crc_run;
    logic [8:0]  len_run;
    logic [7:0]  addr_run;
    logic [7:0]  func_run;

    result_t expected_results[$];
    result_t first_pred;
    int      errors;
    bit      noidle;
    bit      in_done;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (x[0])
                x = (x >> 1) ^ 16'hA001;
            else
                x = x >> 1;
        end
        return x;
    endfunction

    function automatic void add_result(input logic [1:0] k, input logic [31:0] id,
                                       input logic [7:0] b, input logic [8:0] fl);
        result_t r;
        r.kind = k;
        r.txn_id = id;
        r.tx_byte = b;
        r.frame_length = fl;
        r.last = 1'b0;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void shadow_reset();
        sil_ms = SILENCE_RST;
        tmo_ms = TIMEOUT_RST;
        ret_ms = RETIRE_RST;
        for (int i = 0; i < DEPTH; i++)
            tb_valid[i] = 1'b0;
        id_next = 32'd1;
        ms_now = 0;
        ms_last_byte = 0;
        crc_run = 16'hFFFF;
        len_run = 0;
        addr_run = 0;
        func_run = 0;
    endfunction

    function automatic int close_rx_frame();
        int best;
        logic [31:0] best_age;
        logic [31:0] age;
        int n;
        best = -1;
        best_age = 0;
        n = 0;
        if (len_run >= 9'd5 && crc_run == 16'h0000)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (tb_valid[i] && tb_status[i] == ST_PENDING && tb_slave[i] == addr_run
                    && tb_func[i] == func_run)
                begin
                    age = id_next - tb_id[i];
                    if (best < 0 || age > best_age)
                    begin
                        best = i;
                        best_age = age;
                    end
                end
            end
            if (best >= 0)
            begin
                tb_status[best] = ST_DONE;
                add_result(KIND_DONE, tb_id[best], 8'h00, len_run);
                n = 1;
            end
        end
        crc_run = 16'hFFFF;
        len_run = 0;
        return n;
    endfunction

    function automatic bit silence_over();
        return len_run != 0 && (ms_now - ms_last_byte) > {24'd0, sil_ms};
    endfunction

    // Computes the results of one accepted item and queues them.
    function automatic void predict_engine(input item_t it);
        int n;
        int slot;
        logic [7:0]  fr [8];
        logic [15:0] c;
        logic [31:0] age;
        n = 0;
        slot = -1;
        if (it.operation == OP_REQUEST)
        begin
            for (int i = DEPTH - 1; i >= 0; i--)
                if (!tb_valid[i])
                    slot = i;
            if (slot < 0)
            begin
                add_result(KIND_REJECT, 32'd0, 8'h00, 9'd0);
                n = 1;
            end
            else
            begin
                fr[0] = it.slave_addr;
                fr[1] = it.func_code;
                fr[2] = it.reg_addr[15:8];
                fr[3] = it.reg_addr[7:0];
                fr[4] = it.count_or_value[15:8];
                fr[5] = it.count_or_value[7:0];
                c = 16'hFFFF;
                for (int i = 0; i < 6; i++)
                    c = crc_step(c, fr[i]);
                fr[6] = c[7:0];
                fr[7] = c[15:8];
                tb_valid[slot] = 1'b1;
                tb_id[slot] = id_next;
                tb_slave[slot] = fr[0];
                tb_func[slot] = fr[1];
                tb_status[slot] = ST_PENDING;
                tb_stamp[slot] = ms_now;
                for (int i = 0; i < 8; i++)
                    add_result(KIND_TX_BYTE, id_next, fr[i], 9'd0);
                n = 8;
                id_next++;
                if (id_next == 0)
                    id_next = 32'd1;
            end
        end
        else if (it.operation == OP_RX_BYTE)
        begin
            if (silence_over())
                n += close_rx_frame();
            if (len_run == 0)
                addr_run = it.rx_byte;
            else if (len_run == 1)
                func_run = it.rx_byte;
            crc_run = crc_step(crc_run, it.rx_byte);
            if (len_run < 9'd256)
                len_run++;
            ms_last_byte = ms_now;
        end
        else if (it.operation == OP_TICK)
        begin
            ms_now++;
            if (silence_over())
                n += close_rx_frame();
            for (int i = 0; i < DEPTH; i++)
            begin
                if (tb_valid[i])
                begin
                    age = ms_now - tb_stamp[i];
                    if (tb_status[i] == ST_PENDING && age > {16'd0, tmo_ms} && n < MAX_RESULTS)
                    begin
                        tb_status[i] = ST_TIMEOUT;
                        add_result(KIND_TIMEOUT, tb_id[i], 8'h00, 9'd0);
                        n++;
                    end
                    if (tb_status[i] != ST_PENDING && age > {16'd0, ret_ms})
                        tb_valid[i] = 1'b0;
                end
            end
        end
        if (n > 0)
        begin
            expected_results[$].last = 1'b1;
            first_pred = expected_results[expected_results.size() - n];
        end
    endfunction

    // Result side: random stalls and field checks.
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                    report($sformatf("unexpected result kind %0d id %0d", kind, txn_id));
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (kind !== exp_r.kind || txn_id !== exp_r.txn_id
                        || tx_byte !== exp_r.tx_byte || frame_length !== exp_r.frame_length
                        || last !== exp_r.last)
                        report($sformatf("got %0d/%0d/%h/%0d/%0d expected %0d/%0d/%h/%0d/%0d",
                            kind, txn_id, tx_byte, frame_length, last, exp_r.kind,
                            exp_r.txn_id, exp_r.tx_byte, exp_r.frame_length, exp_r.last));
                end
            end
            pop <= noidle || ($urandom_range(99) >= 31);
        end
    end

    task automatic send_request(input item_t it);
        push <= 1'b1;
        operation <= it.operation;
        slave_addr <= it.slave_addr;
        func_code <= it.func_code;
        reg_addr <= it.reg_addr;
        count_or_value <= it.count_or_value;
        rx_byte <= it.rx_byte;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_engine(it);
        if (!noidle)
        begin
            while ($urandom_range(99) < 31)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic stop_push();
        push <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drain();
        stop_push();
        while (expected_results.size() != 0)
            @(posedge clk);
        // A byte or tick with no result may still be sweeping the table.
        repeat (100)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_SILENCE)
            sil_ms = val[7:0];
        else if (idx == CFG_TIMEOUT)
            tmo_ms = val;
        else if (idx == CFG_RETIRE)
            ret_ms = val;
        @(posedge clk);
    endtask

    function automatic item_t mk_item(input logic [1:0] op, input logic [7:0] sa,
                                      input logic [7:0] fc, input logic [15:0] ra,
                                      input logic [15:0] cv, input logic [7:0] rb);
        item_t it;
        it.operation = op;
        it.slave_addr = sa;
        it.func_code = fc;
        it.reg_addr = ra;
        it.count_or_value = cv;
        it.rx_byte = rb;
        return it;
    endfunction

    function automatic item_t rand_item(input logic [1:0] op);
        return mk_item(op, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                       8'($urandom));
    endfunction

    // Sends a well-formed response frame for a slave/function, optionally corrupted.
    task automatic send_response(input logic [7:0] sa, input logic [7:0] fc,
                                 input int nbody, input bit corrupt);
        logic [15:0] c;
        logic [7:0]  b;
        item_t       it;
        c = 16'hFFFF;
        for (int i = 0; i < nbody + 2; i++)
        begin
            if (i == 0)
                b = sa;
            else if (i == 1)
                b = fc;
            else
                b = 8'($urandom);
            c = crc_step(c, b);
            it = rand_item(OP_RX_BYTE);
            it.rx_byte = b;
            send_request(it);
        end
        if (corrupt)
            c = c ^ 16'h0100;
        it = rand_item(OP_RX_BYTE);
        it.rx_byte = c[7:0];
        send_request(it);
        it = rand_item(OP_RX_BYTE);
        it.rx_byte = c[15:8];
        send_request(it);
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++)
            send_request(rand_item(OP_TICK));
    endtask

    // Directed rows: some carry the expected first result typed in; has_chk marks those.
    typedef struct {
        item_t       it;
        bit          has_chk;
        logic [1:0]  chk_kind;
        logic [31:0] chk_id;
    } row_t;

    row_t rows[$];

    function automatic void add_row(input item_t it, input bit hc, input logic [1:0] k,
                                    input logic [31:0] id);
        row_t r;
        r.it = it;
        r.has_chk = hc;
        r.chk_kind = k;
        r.chk_id = id;
        rows.insert(rows.size(), r);
    endfunction

    initial
    begin
        int cnt;
        int pend_slave;
        logic [7:0] rs [DEPTH];
        logic [7:0] rf [DEPTH];
        int nreq;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        operation = OP_TICK;
        slave_addr = 0;
        func_code = 0;
        reg_addr = 0;
        count_or_value = 0;
        rx_byte = 0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SILENCE;
        cfg_data = 0;
        errors = 0;
        noidle = 1'b0;
        in_done = 1'b0;
        nreq = 0;
        shadow_reset();
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: extremes, id sequence from reset, table full, ignored operation.
        add_row(mk_item(OP_REQUEST, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00), 1,
                KIND_TX_BYTE, 32'd1);
        add_row(mk_item(OP_REQUEST, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1,
                KIND_TX_BYTE, 32'd2);
        add_row(mk_item(OP_REQUEST, 8'h11, 8'h03, 16'h006B, 16'h0003, 8'h00), 1,
                KIND_TX_BYTE, 32'd3);
        for (int i = 0; i < 5; i++)
            add_row(mk_item(OP_REQUEST, 8'h01, 8'h06, 16'h1234, 16'hABCD, 8'h00), 0,
                    KIND_TX_BYTE, 0);
        add_row(mk_item(OP_REQUEST, 8'h01, 8'h04, 16'h0000, 16'h0001, 8'h00), 1,
                KIND_REJECT, 32'd0);
        add_row(mk_item(OP_IGNORED, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF), 0,
                KIND_TX_BYTE, 0);
        add_row(mk_item(OP_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'hFF), 0,
                KIND_TX_BYTE, 0);
        add_row(mk_item(OP_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00), 0,
                KIND_TX_BYTE, 0);
        add_row(mk_item(OP_TICK, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00), 0,
                KIND_TX_BYTE, 0);
        foreach (rows[i])
        begin
            send_request(rows[i].it);
            if (rows[i].has_chk)
            begin
                if (first_pred.kind !== rows[i].chk_kind
                    || first_pred.txn_id !== rows[i].chk_id)
                    report($sformatf("directed row %0d: predictor disagrees with table", i));
            end
        end
        wait_drain();

        // Short timeouts: the full table expires over a few ticks, then retires.
        write_reg(CFG_SILENCE, 16'd0);
        write_reg(CFG_TIMEOUT, 16'd1);
        write_reg(CFG_RETIRE, 16'd1);
        send_ticks(6);
        // Valid response to a fresh request, including a long frame.
        send_request(mk_item(OP_REQUEST, 8'h22, 8'h03, 16'h0001, 16'h0002, 8'h00));
        send_response(8'h22, 8'h03, 3, 0);
        send_ticks(1);
        send_request(mk_item(OP_REQUEST, 8'h23, 8'h04, 16'h0001, 16'h0002, 8'h00));
        send_response(8'h23, 8'h04, 258, 0);
        send_ticks(8);
        wait_drain();

        // Register extremes, then the main random phases under several settings.
        write_reg(CFG_SILENCE, 16'd255);
        write_reg(CFG_TIMEOUT, 16'd65535);
        write_reg(CFG_RETIRE, 16'd65535);
        send_request(mk_item(OP_REQUEST, 8'h05, 8'h06, 16'h0000, 16'h0000, 8'h00));
        send_response(8'h05, 8'h06, 2, 0);
        send_ticks(3);
        wait_drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 0)
            begin
                write_reg(CFG_SILENCE, 16'd1);
                write_reg(CFG_TIMEOUT, 16'd12);
                write_reg(CFG_RETIRE, 16'd20);
            end
            else if (ph == 1)
            begin
                write_reg(CFG_SILENCE, 16'd0);
                write_reg(CFG_TIMEOUT, 16'd40);
                write_reg(CFG_RETIRE, 16'd3);
                noidle = 1'b1;
            end
            else
            begin
                write_reg(CFG_SILENCE, 16'd2);
                write_reg(CFG_TIMEOUT, 16'd6);
                write_reg(CFG_RETIRE, 16'd65535);
                noidle = 1'b0;
            end
            cnt = 0;
            while (cnt < 60)
            begin
                case ($urandom_range(9))
                    0, 1, 2:
                    begin
                        // Few slave/function pairs so that responses find matches.
                        rs[nreq % DEPTH] = 8'($urandom_range(3));
                        rf[nreq % DEPTH] = ($urandom_range(1) != 0) ? 8'h03 : 8'h06;
                        send_request(mk_item(OP_REQUEST, rs[nreq % DEPTH], rf[nreq % DEPTH],
                                             16'($urandom), 16'($urandom), 8'($urandom)));
                        nreq++;
                        cnt++;
                    end
                    3, 4:
                    begin
                        pend_slave = $urandom_range(DEPTH - 1);
                        if (nreq > 0)
                        begin
                            send_response(rs[pend_slave % (nreq < DEPTH ? nreq : DEPTH)],
                                          rf[pend_slave % (nreq < DEPTH ? nreq : DEPTH)],
                                          $urandom_range(4), $urandom_range(7) == 0);
                            cnt += 5;
                        end
                        send_ticks(ph + 3);
                        cnt += ph + 3;
                    end
                    5:
                    begin
                        for (int j = 0; j < $urandom_range(6, 1); j++)
                        begin
                            send_request(rand_item(OP_RX_BYTE));
                            cnt++;
                        end
                    end
                    6:
                    begin
                        send_request(rand_item(2'($urandom_range(3))));
                        cnt++;
                    end
                    default:
                    begin
                        send_ticks($urandom_range(4, 1));
                        cnt += 2;
                    end
                endcase
            end
            wait_drain();
        end

        in_done = 1'b1;
        cnt = 0;
        while (expected_results.size() != 0 && cnt < 100000)
        begin
            @(posedge clk);
            cnt++;
        end
        repeat (100)
            @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[sim.f]
design/mbr_pkg.sv
design/mbr_front.sv
design/mbr_outq.sv
design/mbr_engine.sv
design/modbus_rtu_master_transaction_engine.sv
tb/sv/tb_modbus_rtu_master_transaction_engine.sv
